@@ rtl/core/spreadsheet_date_serial_convert_macros.svh @@
// ---------------------------------------------------------------------------
// Spreadsheet date serial converter: assertion macros
// Shorthand for the clocked checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef SPREADSHEET_DATE_SERIAL_CONVERT_MACROS_SVH
`define SPREADSHEET_DATE_SERIAL_CONVERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted
`define SDSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, ignored while reset is asserted
`define SDSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/ssdc_pkg.sv @@
// ---------------------------------------------------------------------------
// Spreadsheet date serial converter: shared package
// Field widths, calendar constants, reciprocal multipliers for the constant
// divisions, and the small calendar tables used by both datapaths.
// ---------------------------------------------------------------------------
package ssdc_pkg;

	// Pipeline depth, identical for both conversion directions
	localparam int NSTG = 9;

	// Field widths
	localparam int YEAR_W     = 16;
	localparam int MONTH_W    = 4;
	localparam int DAY_W      = 5;
	localparam int SERIAL_W   = 25;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 56;

	// Conversion direction carried in tuser
	typedef enum logic {
		OP_DATE_TO_SERIAL = 1'b0,
		OP_SERIAL_TO_DATE = 1'b1
	} op_t;

	// Stage enables and the date system, fanned out to both datapaths
	typedef struct packed {
		logic [NSTG:1] en;
		logic          sys_1904;
	} ssdc_ctl_t;

	// Calendar constants
	localparam int BASE_BEFORE_GHOST = 25568;
	localparam int BASE_AFTER_GHOST  = 25569;
	localparam int OFFSET_1904       = 1462;
	localparam int CIVIL_1900_FEB28  = -25509;
	localparam int EPOCH_SHIFT       = 719468;
	localparam int DAYS_PER_ERA      = 146097;
	localparam int DAYS_PER_ERA_M1   = 146096;
	localparam int YEARS_PER_ERA     = 400;
	localparam int DAYS_PER_YEAR     = 365;
	localparam int GHOST_SERIAL      = 60;
	localparam int GHOST_YEAR        = 1900;
	localparam int GHOST_MONTH       = 2;
	localparam int GHOST_DAY         = 29;
	localparam int MONTH_MIN         = 1;
	localparam int MONTH_MAX         = 12;

	// Bias that makes the shifted year non-negative (whole eras)
	localparam int YEAR_BIAS_ERAS = 82;
	localparam int YEAR_BIAS      = YEAR_BIAS_ERAS * YEARS_PER_ERA;

	// Bias that makes the shifted day count non-negative (whole eras)
	localparam int SERIAL_BIAS_ERAS = 111;
	localparam int SERIAL_BIAS      = EPOCH_SHIFT + SERIAL_BIAS_ERAS * DAYS_PER_ERA;

	// Reciprocals: q = (x * M) >> K, with K = width(x) + width(divisor)
	localparam int K400   = 26;
	localparam logic [17:0] M400 = 18'(((64'd1 << K400) + 64'd399) / 64'd400);
	localparam int K_ERA  = 44;
	localparam logic [26:0] M_ERA = 27'(((64'd1 << K_ERA) + 64'd146096) / 64'd146097);
	localparam int K100   = 16;
	localparam logic [9:0]  M100 = 10'(((64'd1 << K100) + 64'd99) / 64'd100);
	localparam int K1460  = 29;
	localparam logic [18:0] M1460 = 19'(((64'd1 << K1460) + 64'd1459) / 64'd1460);
	localparam int K36524 = 34;
	localparam logic [18:0] M36524 = 19'(((64'd1 << K36524) + 64'd36523) / 64'd36524);
	localparam int K365   = 27;
	localparam logic [18:0] M365 = 19'(((64'd1 << K365) + 64'd364) / 64'd365);
	localparam int K153   = 19;
	localparam logic [11:0] M153 = 12'(((64'd1 << K153) + 64'd152) / 64'd153);

	// Days before the start of each month, counted from March
	function automatic logic [8:0] cum_days(input logic [3:0] mp);
		logic [8:0] r;
		case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// Days in the era before year-of-era yoe: 365*yoe + yoe/4 - yoe/100
	function automatic logic [17:0] yoe_days(input logic [8:0] yoe);
		logic [18:0] p100;
		logic [1:0]  q100;
		p100 = 19'(yoe) * 19'(M100);
		q100 = p100[K100 +: 2];
		return 18'(yoe) * 18'(DAYS_PER_YEAR) + 18'(yoe[8:2]) - 18'(q100);
	endfunction

endpackage

@@ rtl/core/ssdc_to_serial.sv @@
// ---------------------------------------------------------------------------
// Spreadsheet date serial converter: date to serial datapath
// Nine-stage pipeline computing the civil day count of a year/month/day and
// adding the spreadsheet offset of the selected date system.
// ---------------------------------------------------------------------------
module ssdc_to_serial import ssdc_pkg::*; (
	input  logic                       clk,
	input  ssdc_ctl_t                  ctl,
	input  logic signed [YEAR_W-1:0]   year_in,
	input  logic [MONTH_W-1:0]         month_in,
	input  logic [DAY_W-1:0]           day_in,
	output logic signed [SERIAL_W-1:0] serial_out
);

	// Stage 1 inputs
	logic [MONTH_W-1:0] month_c;
	logic               month_low;
	logic [17:0]        t_sum;
	logic [3:0]         mp_d;
	logic [8:0]         doy1_d;
	logic               ghost_d;

	// Pipeline registers
	logic [16:0] t_s1, t_s2;
	logic [8:0]  doy1_s1, doy1_s2, doy1_s3;
	logic        ghost_s1, ghost_s2, ghost_s3, ghost_s4, ghost_s5;
	logic        sys_s1, sys_s2, sys_s3, sys_s4, sys_s5;
	logic [7:0]  qy_s2;
	logic [8:0]  yoe_s3;
	logic [7:0]  era_s3, era_s4;
	logic [17:0] doe1_s4;
	logic [25:0] cnt_s5;
	logic [24:0] ser_s6, ser_s7, ser_s8, ser_s9;

	// Combinational stage results
	logic [34:0] p400;
	logic [16:0] yoe_full;
	logic [25:0] cnt_d;
	logic [25:0] sum_1904;
	logic [25:0] sum_1900;
	logic        before_ghost;

	// Clamp the month, shift the year so March opens it, bias to non-negative
	always_comb begin
		month_c = month_in;
		if (month_in < 4'(MONTH_MIN)) begin
			month_c = 4'(MONTH_MIN);
		end else if (month_in > 4'(MONTH_MAX)) begin
			month_c = 4'(MONTH_MAX);
		end
		month_low = (month_c <= 4'd2);
		t_sum     = {{2{year_in[YEAR_W-1]}}, year_in} - {17'd0, month_low} + 18'(YEAR_BIAS);
		mp_d      = (month_c > 4'd2) ? month_c - 4'd3 : month_c + 4'd9;
		doy1_d    = cum_days(mp_d) + 9'(day_in);
		ghost_d   = (year_in == 16'(GHOST_YEAR)) && (month_c == 4'(GHOST_MONTH))
			&& (day_in == 5'(GHOST_DAY));
	end

	// Era by reciprocal, then year of era and day count
	assign p400     = 35'(t_s1) * 35'(M400);
	assign yoe_full = t_s2 - 17'(qy_s2) * 17'(YEARS_PER_ERA);
	assign cnt_d    = {{18{era_s4[7]}}, era_s4} * 26'(DAYS_PER_ERA) + 26'(doe1_s4)
		- 26'(EPOCH_SHIFT + 1);

	// Add the offset of the date system; in the 1900 system the ghost date maps to its own serial
	always_comb begin
		sum_1904     = cnt_s5 + 26'(BASE_AFTER_GHOST - OFFSET_1904);
		before_ghost = $signed(cnt_s5) <= $signed(26'(CIVIL_1900_FEB28));
		sum_1900     = cnt_s5 + (before_ghost ? 26'(BASE_BEFORE_GHOST)
			: 26'(BASE_AFTER_GHOST));
	end

	// Advance each stage on its enable
	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			t_s1     <= t_sum[16:0];
			doy1_s1  <= doy1_d;
			ghost_s1 <= ghost_d;
			sys_s1   <= ctl.sys_1904;
		end
		if (ctl.en[2]) begin
			qy_s2    <= p400[K400 +: 8];
			t_s2     <= t_s1;
			doy1_s2  <= doy1_s1;
			ghost_s2 <= ghost_s1;
			sys_s2   <= sys_s1;
		end
		if (ctl.en[3]) begin
			yoe_s3   <= yoe_full[8:0];
			era_s3   <= qy_s2 - 8'(YEAR_BIAS_ERAS);
			doy1_s3  <= doy1_s2;
			ghost_s3 <= ghost_s2;
			sys_s3   <= sys_s2;
		end
		if (ctl.en[4]) begin
			doe1_s4  <= yoe_days(yoe_s3) + 18'(doy1_s3);
			era_s4   <= era_s3;
			ghost_s4 <= ghost_s3;
			sys_s4   <= sys_s3;
		end
		if (ctl.en[5]) begin
			cnt_s5   <= cnt_d;
			ghost_s5 <= ghost_s4;
			sys_s5   <= sys_s4;
		end
		if (ctl.en[6]) begin
			if (sys_s5) begin
				ser_s6 <= sum_1904[24:0];
			end else if (ghost_s5) begin
				ser_s6 <= 25'(GHOST_SERIAL);
			end else begin
				ser_s6 <= sum_1900[24:0];
			end
		end
		if (ctl.en[7]) begin
			ser_s7 <= ser_s6;
		end
		if (ctl.en[8]) begin
			ser_s8 <= ser_s7;
		end
		if (ctl.en[9]) begin
			ser_s9 <= ser_s8;
		end
	end

	assign serial_out = $signed(ser_s9);

endmodule

@@ rtl/core/ssdc_to_date.sv @@
// ---------------------------------------------------------------------------
// Spreadsheet date serial converter: serial to date datapath
// Nine-stage pipeline removing the spreadsheet offset and splitting the day
// count into era, year of era, day of year, month and day.
// ---------------------------------------------------------------------------
module ssdc_to_date import ssdc_pkg::*; (
	input  logic                       clk,
	input  ssdc_ctl_t                  ctl,
	input  logic signed [SERIAL_W-1:0] serial_in,
	output logic signed [YEAR_W-1:0]   year_out,
	output logic [MONTH_W-1:0]         month_out,
	output logic [DAY_W-1:0]           day_out
);

	// Stage 1 inputs
	logic        below_ghost;
	logic [26:0] off_d;
	logic [26:0] u_sum;
	logic        ghost_d;

	// Pipeline registers
	logic [25:0] u_s1, u_s2;
	logic        ghost_s1, ghost_s2, ghost_s3, ghost_s4, ghost_s5, ghost_s6, ghost_s7;
	logic        ghost_s8;
	logic [7:0]  qe_s2;
	logic [7:0]  era_s3, era_s4, era_s5, era_s6, era_s7, era_s8;
	logic [17:0] doe_s3, doe_s4, doe_s5, doe_s6;
	logic [6:0]  a_s4;
	logic [2:0]  b_s4;
	logic        c_s4;
	logic [17:0] x_s5;
	logic [8:0]  yoe_s6, yoe_s7, yoe_s8;
	logic [8:0]  doy_s7, doy_s8;
	logic [3:0]  mp_s8;
	logic [YEAR_W-1:0]  year_s9;
	logic [MONTH_W-1:0] month_s9;
	logic [DAY_W-1:0]   day_s9;

	// Combinational stage results
	logic [52:0] p_era;
	logic [25:0] doe_full;
	logic [36:0] p1460;
	logic [36:0] p36524;
	logic [36:0] p365;
	logic [17:0] doy_full;
	logic [10:0] v153;
	logic [22:0] p153;
	logic [8:0]  day_full;
	logic [3:0]  month_d;
	logic [15:0] year_d;

	// Remove the serial offset and bias the day count to whole positive eras
	always_comb begin
		below_ghost = $signed(serial_in) < $signed(25'(GHOST_SERIAL));
		if (ctl.sys_1904) begin
			off_d = 27'(BASE_AFTER_GHOST - OFFSET_1904);
		end else if (below_ghost) begin
			off_d = 27'(BASE_BEFORE_GHOST);
		end else begin
			off_d = 27'(BASE_AFTER_GHOST);
		end
		u_sum   = {{2{serial_in[SERIAL_W-1]}}, serial_in} + 27'(SERIAL_BIAS) - off_d;
		ghost_d = !ctl.sys_1904 && (serial_in == 25'(GHOST_SERIAL));
	end

	// Era, day of era, year of era and month index by reciprocals
	assign p_era    = 53'(u_s1) * 53'(M_ERA);
	assign doe_full = u_s2 - 26'(qe_s2) * 26'(DAYS_PER_ERA);
	assign p1460    = 37'(doe_s3) * 37'(M1460);
	assign p36524   = 37'(doe_s3) * 37'(M36524);
	assign p365     = 37'(x_s5) * 37'(M365);
	assign doy_full = doe_s6 - yoe_days(yoe_s6);
	assign v153     = {doy_s7, 2'b00} + 11'(doy_s7) + 11'd2;
	assign p153     = 23'(v153) * 23'(M153);

	// Rebuild day, month and year; the ghost serial has a fixed date
	always_comb begin
		day_full = doy_s8 - cum_days(mp_s8) + 9'd1;
		month_d  = (mp_s8 < 4'd10) ? mp_s8 + 4'd3 : mp_s8 - 4'd9;
		year_d   = 16'(yoe_s8) + {{8{era_s8[7]}}, era_s8} * 16'(YEARS_PER_ERA)
			+ 16'(month_d <= 4'd2);
	end

	// Advance each stage on its enable
	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			u_s1     <= u_sum[25:0];
			ghost_s1 <= ghost_d;
		end
		if (ctl.en[2]) begin
			qe_s2    <= p_era[K_ERA +: 8];
			u_s2     <= u_s1;
			ghost_s2 <= ghost_s1;
		end
		if (ctl.en[3]) begin
			doe_s3   <= doe_full[17:0];
			era_s3   <= qe_s2 - 8'(SERIAL_BIAS_ERAS);
			ghost_s3 <= ghost_s2;
		end
		if (ctl.en[4]) begin
			a_s4     <= p1460[K1460 +: 7];
			b_s4     <= p36524[K36524 +: 3];
			c_s4     <= (doe_s3 == 18'(DAYS_PER_ERA_M1));
			doe_s4   <= doe_s3;
			era_s4   <= era_s3;
			ghost_s4 <= ghost_s3;
		end
		if (ctl.en[5]) begin
			x_s5     <= doe_s4 - 18'(a_s4) + 18'(b_s4) - 18'(c_s4);
			doe_s5   <= doe_s4;
			era_s5   <= era_s4;
			ghost_s5 <= ghost_s4;
		end
		if (ctl.en[6]) begin
			yoe_s6   <= p365[K365 +: 9];
			doe_s6   <= doe_s5;
			era_s6   <= era_s5;
			ghost_s6 <= ghost_s5;
		end
		if (ctl.en[7]) begin
			doy_s7   <= doy_full[8:0];
			yoe_s7   <= yoe_s6;
			era_s7   <= era_s6;
			ghost_s7 <= ghost_s6;
		end
		if (ctl.en[8]) begin
			mp_s8    <= p153[K153 +: 4];
			doy_s8   <= doy_s7;
			yoe_s8   <= yoe_s7;
			era_s8   <= era_s7;
			ghost_s8 <= ghost_s7;
		end
		if (ctl.en[9]) begin
			if (ghost_s8) begin
				year_s9  <= 16'(GHOST_YEAR);
				month_s9 <= 4'(GHOST_MONTH);
				day_s9   <= 5'(GHOST_DAY);
			end else begin
				year_s9  <= year_d;
				month_s9 <= month_d;
				day_s9   <= day_full[4:0];
			end
		end
	end

	assign year_out  = $signed(year_s9);
	assign month_out = month_s9;
	assign day_out   = day_s9;

endmodule

@@ rtl/core/spreadsheet_date_serial_convert.sv @@
// ---------------------------------------------------------------------------
// Spreadsheet date serial converter
// Converts proleptic Gregorian dates to spreadsheet day serials and back,
// in the 1900 system (with its fictitious leap day) or the 1904 system.
//
// Channel   | Dir | Handshake         | Payload
// ----------|-----|-------------------|-----------------------------------------
// s_axis    | in  | tvalid/tready     | tuser op, tdata year/month/day/serial
// m_axis    | out | tvalid/tready     | tdata serial/year/month/day
// apb       | in  | psel/penable      | register 0: date system select
//
// Accepts one word per cycle unless the output stalls; depth is set by the
// serial to date chain of reciprocal multiplies (era, leap corrections, year,
// month). Reset clears all stage valid bits and selects the 1900 date system.
// Each stage holds while the stage after it is full and stalled; empty
// stages fill, so input is taken while a finished word waits at the output.
// ---------------------------------------------------------------------------
`include "spreadsheet_date_serial_convert_macros.svh"

module spreadsheet_date_serial_convert import ssdc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// Input words
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // year_in[15:0], month_in[19:16],
	                                             // day_in[24:20], serial_in[49:25], zero
	input  logic                  s_axis_tuser,  // op[0]
	// Result words
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // serial_out[24:0], year_out[40:25],
	                                             // month_out[44:41], day_out[49:45], zero
	// Configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	localparam logic REG_DATE_SYSTEM = 1'b0;
	localparam int   OUT_FIELDS_W    = SERIAL_W + YEAR_W + MONTH_W + DAY_W;

	logic                  sys_q;
	logic [NSTG:1]         vld_q;
	logic [NSTG:1]         op_q;
	logic [NSTG+1:1]       en;
	ssdc_ctl_t             ctl;

	logic signed [SERIAL_W-1:0] ser_w;
	logic signed [YEAR_W-1:0]   year_w;
	logic [MONTH_W-1:0]         month_w;
	logic [DAY_W-1:0]           day_w;
	logic [SERIAL_W-1:0]        serial_out_w;
	logic [YEAR_W-1:0]          year_out_w;
	logic [MONTH_W-1:0]         month_out_w;
	logic [DAY_W-1:0]           day_out_w;
	logic                       out_is_date;

	// Register write and read-back
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_DATE_SYSTEM) ? {31'd0, sys_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sys_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_DATE_SYSTEM)) begin
			sys_q <= pwdata[0];
		end
	end

	// Stage enables: a stage advances when empty or when the next one advances
	always_comb begin
		en[NSTG+1] = m_axis_tready;
		for (int i = NSTG; i >= 1; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	assign s_axis_tready = en[1];
	assign m_axis_tvalid = vld_q[NSTG];
	assign ctl.en        = en[NSTG:1];
	assign ctl.sys_1904  = sys_q;

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= s_axis_tvalid;
			end
			for (int i = 2; i <= NSTG; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	// Conversion direction travels with the data
	always_ff @(posedge clk) begin
		if (en[1]) begin
			op_q[1] <= s_axis_tuser;
		end
		for (int i = 2; i <= NSTG; i++) begin
			if (en[i]) begin
				op_q[i] <= op_q[i-1];
			end
		end
	end

	ssdc_to_serial u_to_serial (
		.clk        (clk),
		.ctl        (ctl),
		.year_in    (s_axis_tdata[15:0]),
		.month_in   (s_axis_tdata[19:16]),
		.day_in     (s_axis_tdata[24:20]),
		.serial_out (ser_w)
	);

	ssdc_to_date u_to_date (
		.clk       (clk),
		.ctl       (ctl),
		.serial_in (s_axis_tdata[49:25]),
		.year_out  (year_w),
		.month_out (month_w),
		.day_out   (day_w)
	);

	// Zero the fields of the direction not taken
	assign out_is_date  = (op_q[NSTG] == OP_SERIAL_TO_DATE);
	assign serial_out_w = out_is_date ? '0 : ser_w;
	assign year_out_w   = out_is_date ? year_w : '0;
	assign month_out_w  = out_is_date ? month_w : '0;
	assign day_out_w    = out_is_date ? day_w : '0;

	assign m_axis_tdata = {(OUT_DATA_W - OUT_FIELDS_W)'(0), day_out_w, month_out_w,
		year_out_w, serial_out_w};

	// Checks
	`SDSC_ASSERT_IMP(a_ready_chain, clk, arst_n, 1'b1, s_axis_tready == (!(&vld_q) || m_axis_tready), "input ready disagrees with pipeline occupancy")
	`SDSC_ASSERT_NXT(a_accept_fills, clk, arst_n, s_axis_tvalid && s_axis_tready, vld_q[1], "accepted word missing from first stage")
	`SDSC_ASSERT_IMP(a_date_range, clk, arst_n, m_axis_tvalid && out_is_date, (month_out_w >= 4'd1) && (month_out_w <= 4'd12) && (day_out_w >= 5'd1), "date result out of calendar range")

endmodule
